### src/hps_pkg.sv
// ---------------------------------------------------------------------------
// hps_pkg - shared types and constants of the halving pool selector
// Register indexes, widths, reset values and the sequencer state type.
// ---------------------------------------------------------------------------
package hps_pkg;

   localparam int SUBJ_W     = 4;
   localparam int VAR_W      = 2;
   localparam int MASS_W     = 32;
   localparam int SCORE_W    = 33;
   localparam int POOL_OUT_W = 8;
   localparam int PART_IDX_W = 3;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SUBJECTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_VARIANTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MASS  = 2'd2;

   localparam logic [SUBJ_W-1:0] SUBJ_RESET   = 4'd8;
   localparam logic [VAR_W-1:0]  VAR_RESET    = 2'd2;
   localparam logic [MASS_W-1:0] TARGET_RESET = 32'h2000_0000;

   localparam logic [SCORE_W-1:0] SCORE_START = 33'h1_0000_0000;
   localparam logic [SCORE_W-1:0] SCORE_SAT   = 33'h1_FFFF_FFFF;
   localparam logic [MASS_W-1:0]  MASS_SAT    = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_DRAIN,
      ST_SCORE,
      ST_SWEEP,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic                  clear;
      logic                  score_en;
      logic [PART_IDX_W-1:0] score_idx;
   } cell_ctrl_type;

endpackage

### src/hps_cell.sv
// ---------------------------------------------------------------------------
// hps_cell - one candidate pool
// Holds the partition accumulators and score of one pool, forwards the
// state word and the running best candidate to its neighbor each cycle.
// ---------------------------------------------------------------------------
module hps_cell
   import hps_pkg::*;
#(
   parameter int MAX_SUBJECTS = 8,
   parameter int MAX_VARIANTS = 2,
   parameter int POOL_ID      = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [SUBJ_W-1:0]                    eff_s,
   input  logic [VAR_W-1:0]                     eff_v,
   input  logic [MASS_W-1:0]                    target_mass,
   input  cell_ctrl_type                        ctrl,
   input  logic                                 item_valid_i,
   input  logic                                 item_last_i,
   input  logic [MASS_W-1:0]                    item_mass_i,
   input  logic [MAX_VARIANTS*MAX_SUBJECTS-1:0] item_fields_i,
   input  logic [MAX_VARIANTS-1:0]              item_ven_i,
   output logic                                 item_valid_o,
   output logic                                 item_last_o,
   output logic [MASS_W-1:0]                    item_mass_o,
   output logic [MAX_VARIANTS*MAX_SUBJECTS-1:0] item_fields_o,
   output logic [MAX_VARIANTS-1:0]              item_ven_o,
   input  logic [SCORE_W-1:0]                   cand_score_i,
   input  logic [MAX_SUBJECTS-1:0]              cand_pool_i,
   output logic [SCORE_W-1:0]                   cand_score_o,
   output logic [MAX_SUBJECTS-1:0]              cand_pool_o
);

   localparam int PARTS = 1 << MAX_VARIANTS;
   localparam logic [MAX_SUBJECTS-1:0] PID = MAX_SUBJECTS'(POOL_ID);

   logic                                 valid_ff, valid_in;
   logic                                 last_ff;
   logic [MASS_W-1:0]                    mass_ff;
   logic [MAX_VARIANTS*MAX_SUBJECTS-1:0] fields_ff;
   logic [MAX_VARIANTS-1:0]              ven_ff;
   logic [MASS_W-1:0]                    acc_ff [PARTS];
   logic [MASS_W-1:0]                    acc_in [PARTS];
   logic [SCORE_W-1:0]                   score_ff, score_in;
   logic [SCORE_W-1:0]                   cscore_ff, cscore_in;
   logic [MAX_SUBJECTS-1:0]              cpool_ff, cpool_in;
   logic                                 active;
   logic [MAX_VARIANTS-1:0]              part_id;
   logic [MASS_W:0]                      acc_sum;
   logic [MASS_W-1:0]                    acc_sel, dev;
   logic [SCORE_W:0]                     score_sum;
   logic                                 idx_ok;

   assign active = (32'(POOL_ID) >> eff_s) == 32'd0;
   assign valid_in = item_valid_i;

   always_comb begin
      for (int v = 0; v < MAX_VARIANTS; v++) begin
         part_id[v] = ven_ff[v] &&
            ((PID & fields_ff[v*MAX_SUBJECTS +: MAX_SUBJECTS]) != PID);
      end
   end

   assign acc_sum = {1'b0, acc_ff[part_id]} + {1'b0, mass_ff};

   always_comb begin
      for (int j = 0; j < PARTS; j++) begin
         if (ctrl.clear) begin
            acc_in[j] = '0;
         end else if (valid_ff && active && (part_id == MAX_VARIANTS'(j))) begin
            acc_in[j] = acc_sum[MASS_W] ? MASS_SAT : acc_sum[MASS_W-1:0];
         end else begin
            acc_in[j] = acc_ff[j];
         end
      end
   end

   // score one partition per step, skipping unused partition codes
   assign idx_ok    = (32'(ctrl.score_idx) >> eff_v) == 32'd0;
   assign acc_sel   = acc_ff[ctrl.score_idx[MAX_VARIANTS-1:0]];
   assign dev       = (acc_sel > target_mass) ? acc_sel - target_mass
                                              : target_mass - acc_sel;
   assign score_sum = {1'b0, score_ff} + {2'b0, dev};

   always_comb begin
      if (ctrl.clear) begin
         score_in = '0;
      end else if (ctrl.score_en && idx_ok) begin
         score_in = (score_sum > {1'b0, SCORE_SAT}) ? SCORE_SAT
                                                  : score_sum[SCORE_W-1:0];
      end else begin
         score_in = score_ff;
      end
   end

   // strict compare keeps the lower pool on ties
   always_comb begin
      if (active && (score_ff < cand_score_i)) begin
         cscore_in = score_ff;
         cpool_in  = PID;
      end else begin
         cscore_in = cand_score_i;
         cpool_in  = cand_pool_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         score_ff <= '0;
         for (int j = 0; j < PARTS; j++) acc_ff[j] <= '0;
      end else begin
         valid_ff <= valid_in;
         score_ff <= score_in;
         for (int j = 0; j < PARTS; j++) acc_ff[j] <= acc_in[j];
      end
   end

   always_ff @(posedge clock) begin
      last_ff   <= item_last_i;
      mass_ff   <= item_mass_i;
      fields_ff <= item_fields_i;
      ven_ff    <= item_ven_i;
      cscore_ff <= cscore_in;
      cpool_ff  <= cpool_in;
   end

   assign item_valid_o  = valid_ff;
   assign item_last_o   = last_ff;
   assign item_mass_o   = mass_ff;
   assign item_fields_o = fields_ff;
   assign item_ven_o    = ven_ff;
   assign cand_score_o  = cscore_ff;
   assign cand_pool_o   = cpool_ff;

endmodule

### src/hps_ctrl.sv
// ---------------------------------------------------------------------------
// hps_ctrl - run sequencer
// Counts states, splits each state index into per-variant subject fields,
// and steps the cell row through drain, scoring, sweep and result.
// ---------------------------------------------------------------------------
module hps_ctrl
   import hps_pkg::*;
#(
   parameter int MAX_SUBJECTS = 8,
   parameter int MAX_VARIANTS = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [SUBJ_W-1:0]                    eff_s,
   input  logic [VAR_W-1:0]                     eff_v,
   output logic                                 item_valid,
   output logic                                 item_last,
   output logic [MAX_VARIANTS*MAX_SUBJECTS-1:0] item_fields,
   output logic [MAX_VARIANTS-1:0]              item_ven,
   input  logic                                 chain_last,
   input  logic                                 rsp_busy,
   output logic                                 rsp_load,
   output cell_ctrl_type                        ctrl
);

   localparam int CW    = MAX_SUBJECTS * MAX_VARIANTS;
   localparam int CNTW  = (MAX_SUBJECTS > PART_IDX_W) ? MAX_SUBJECTS : PART_IDX_W;
   localparam logic [CNTW-1:0] LAST_PART = CNTW'((1 << MAX_VARIANTS) - 1);
   localparam logic [CNTW-1:0] LAST_CELL = CNTW'((1 << MAX_SUBJECTS) - 1);

   seq_state_type   state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CNTW-1:0] step_ff, step_in;
   logic [5:0]      sv;
   logic [CW:0]     total, next;
   logic [CW-1:0]   cur;
   logic            accept;

   assign accept = req_valid && req_ready;
   assign sv     = 6'(eff_s) * 6'(eff_v);
   assign total  = (CW+1)'(1) << sv;
   assign cur    = count_ff & (total[CW-1:0] - CW'(1));
   assign next   = {1'b0, count_ff} + (CW+1)'(1);

   always_comb begin
      for (int v = 0; v < MAX_VARIANTS; v++) begin
         item_fields[v*MAX_SUBJECTS +: MAX_SUBJECTS] =
            MAX_SUBJECTS'(cur >> (6'(v) * 6'(eff_s)));
         item_ven[v] = 32'(v) < 32'(eff_v);
      end
   end

   assign item_valid = accept;
   assign item_last  = next >= total;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN:   if (accept && item_last) state_in = ST_DRAIN;
         ST_DRAIN: if (chain_last) state_in = ST_SCORE;
         ST_SCORE: if (step_ff == LAST_PART) state_in = ST_SWEEP;
         ST_SWEEP: if (step_ff == LAST_CELL) state_in = ST_DONE;
         ST_DONE:  if (!rsp_busy) state_in = ST_RUN;
         default:  state_in = ST_RUN;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      rsp_load       = 1'b0;
      ctrl.clear     = 1'b0;
      ctrl.score_en  = 1'b0;
      ctrl.score_idx = step_ff[PART_IDX_W-1:0];
      case (state_ff)
         ST_RUN:   req_ready = 1'b1;
         ST_SCORE: ctrl.score_en = 1'b1;
         ST_DONE: begin
            rsp_load   = !rsp_busy;
            ctrl.clear = !rsp_busy;
         end
         default: ;
      endcase
   end

   always_comb begin
      step_in = '0;
      if ((state_ff == ST_SCORE && state_in == ST_SCORE) ||
          (state_ff == ST_SWEEP && state_in == ST_SWEEP)) begin
         step_in = step_ff + CNTW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = item_last ? '0 : next[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         count_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
      end
   end

endmodule

### src/halving_pool_selector.sv
// ---------------------------------------------------------------------------
// halving_pool_selector - Bayesian halving pool choice over a row of cells
// Usage: stream the posterior mass words of all 2^(S*V) lattice states in
// index order on req_ (one per cycle while req_ready is high). Each word
// walks a row of 2^MAX_SUBJECTS pool cells, one cell per cycle, and each
// cell whose pool index is below 2^S adds it to one of its partition
// accumulators. After the last state the block drops req_ready, waits for
// the row to drain, steps all cells at once through the 2^MAX_VARIANTS
// partition codes (one per cycle, scoring those below 2^V) and sweeps the
// best candidate down the row. The result word (best_pool, best_score)
// then lands in the rsp_ output register, the cells clear and req_ready
// returns. A stalled rsp_ready holds the result; a following run may
// stream meanwhile and waits only at its end.
// csr_ writes (index 0 subjects, 1 variants, 2 target mass) are always
// taken. Reset clears all accumulators, the state count and the
// registers to 8 subjects, 2 variants and a target of one eighth.
// ---------------------------------------------------------------------------
module halving_pool_selector
   import hps_pkg::*;
#(
   parameter int MAX_SUBJECTS = 8,
   parameter int MAX_VARIANTS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MASS_W-1:0]     req_state_mass,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [POOL_OUT_W-1:0] rsp_best_pool,
   output logic [SCORE_W-1:0]    rsp_best_score,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [MASS_W-1:0]     csr_data
);

   localparam int NCELL = 1 << MAX_SUBJECTS;
   localparam int FW    = MAX_VARIANTS * MAX_SUBJECTS;

   logic [SUBJ_W-1:0]     subj_ff, subj_in;
   logic [VAR_W-1:0]      var_ff, var_in;
   logic [MASS_W-1:0]     target_ff, target_in;
   logic [SUBJ_W-1:0]     eff_s;
   logic [VAR_W-1:0]      eff_v;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POOL_OUT_W-1:0] pool_ff;
   logic [SCORE_W-1:0]    score_ff;
   logic                  rsp_load, rsp_busy;
   cell_ctrl_type         ctrl;
   logic [15:0]           pool_wide;

   logic                    iv   [NCELL+1];
   logic                    il   [NCELL+1];
   logic [MASS_W-1:0]       im   [NCELL+1];
   logic [FW-1:0]           ifl  [NCELL+1];
   logic [MAX_VARIANTS-1:0] iven [NCELL+1];
   logic [SCORE_W-1:0]      cs   [NCELL+1];
   logic [MAX_SUBJECTS-1:0] cp   [NCELL+1];

   assign csr_ready = 1'b1;

   always_comb begin
      subj_in   = subj_ff;
      var_in    = var_ff;
      target_in = target_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_SUBJECTS: subj_in   = csr_data[SUBJ_W-1:0];
            CSR_NUM_VARIANTS: var_in    = csr_data[VAR_W-1:0];
            CSR_TARGET_MASS:  target_in = csr_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize clamps to MAX_SUBJECTS or MAX_VARIANTS
   always_comb begin
      if (subj_ff == '0) eff_s = SUBJ_W'(1);
      else if (32'(subj_ff) > MAX_SUBJECTS) eff_s = SUBJ_W'(MAX_SUBJECTS);
      else eff_s = subj_ff;
      if (var_ff == '0) eff_v = VAR_W'(1);
      else if (32'(var_ff) > MAX_VARIANTS) eff_v = VAR_W'(MAX_VARIANTS);
      else eff_v = var_ff;
   end

   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   hps_ctrl #(
      .MAX_SUBJECTS (MAX_SUBJECTS),
      .MAX_VARIANTS (MAX_VARIANTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .eff_s       (eff_s),
      .eff_v       (eff_v),
      .item_valid  (iv[0]),
      .item_last   (il[0]),
      .item_fields (ifl[0]),
      .item_ven    (iven[0]),
      .chain_last  (iv[NCELL] && il[NCELL]),
      .rsp_busy    (rsp_busy),
      .rsp_load    (rsp_load),
      .ctrl        (ctrl)
   );

   assign im[0] = req_state_mass;
   assign cs[0] = SCORE_START;
   assign cp[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      hps_cell #(
         .MAX_SUBJECTS (MAX_SUBJECTS),
         .MAX_VARIANTS (MAX_VARIANTS),
         .POOL_ID      (k)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .eff_s         (eff_s),
         .eff_v         (eff_v),
         .target_mass   (target_ff),
         .ctrl          (ctrl),
         .item_valid_i  (iv[k]),
         .item_last_i   (il[k]),
         .item_mass_i   (im[k]),
         .item_fields_i (ifl[k]),
         .item_ven_i    (iven[k]),
         .item_valid_o  (iv[k+1]),
         .item_last_o   (il[k+1]),
         .item_mass_o   (im[k+1]),
         .item_fields_o (ifl[k+1]),
         .item_ven_o    (iven[k+1]),
         .cand_score_i  (cs[k]),
         .cand_pool_i   (cp[k]),
         .cand_score_o  (cs[k+1]),
         .cand_pool_o   (cp[k+1])
      );
   end

   assign pool_wide = 16'(cp[NCELL]);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subj_ff      <= SUBJ_RESET;
         var_ff       <= VAR_RESET;
         target_ff    <= TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         subj_ff      <= subj_in;
         var_ff       <= var_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         pool_ff  <= pool_wide[POOL_OUT_W-1:0];
         score_ff <= cs[NCELL];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_pool  = pool_ff;
   assign rsp_best_score = score_ff;

endmodule

### sim/tb_halving_pool_selector.sv
// ---------------------------------------------------------------------------
// tb_halving_pool_selector - self-checking bench for the pool selector
// Streams runs of state mass words under many register settings, predicts
// the chosen pool and its score in the bench, and checks every result word
// with random idling, a long receiver stall and a drained pause.
// ---------------------------------------------------------------------------
module tb_halving_pool_selector;
   import hps_pkg::*;

   localparam int PRED_SUBJ  = 8;
   localparam int PRED_VAR   = 2;
   localparam int STORE_SIZE = 1 << (PRED_SUBJ + PRED_VAR);
   localparam int SETTLE     = 600;
   localparam int IDLE_LIMIT = 12000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [POOL_OUT_W-1:0] pool;
      logic [SCORE_W-1:0]    score;
   } pick_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MASS_W-1:0]     req_state_mass = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [POOL_OUT_W-1:0] rsp_best_pool;
   logic [SCORE_W-1:0]    rsp_best_score;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [MASS_W-1:0]     csr_data = '0;

   // predictor copy of the block
   logic [MASS_W-1:0] part_mass [STORE_SIZE];
   int unsigned       states_seen;
   logic [SUBJ_W-1:0] cfg_subj;
   logic [VAR_W-1:0]  cfg_var;
   logic [MASS_W-1:0] cfg_target;

   pick_type pick_q[$];
   int    err_count  = 0;
   int    items_sent = 0;
   int    runs_done  = 0;
   int    picks_seen = 0;
   int    tx_max = 0;
   int    rx_max = 0;
   int    rx_wait = 0;
   int    hold_left = 0;
   int    idle_cycles = 0;
   bit    rsp_fire = 0;

   halving_pool_selector u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_state_mass(req_state_mass),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_best_pool(rsp_best_pool), .rsp_best_score(rsp_best_score),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned eff_subj();
      if (cfg_subj == 0) return 1;
      if (cfg_subj > PRED_SUBJ) return PRED_SUBJ;
      return cfg_subj;
   endfunction

   function automatic int unsigned eff_var();
      if (cfg_var == 0) return 1;
      if (cfg_var > PRED_VAR) return PRED_VAR;
      return cfg_var;
   endfunction

   function automatic int unsigned run_len();
      return 1 << (eff_subj() * eff_var());
   endfunction

   task automatic clear_pred();
      for (int i = 0; i < STORE_SIZE; i++) part_mass[i] = '0;
      states_seen = 0;
   endtask

   // accumulate one state word; return 1 when it closes the run
   function automatic bit accumulate_mass(input logic [MASS_W-1:0] mass, output pick_type r);
      int unsigned s, v, total, st, id, slot, m, d;
      longint unsigned sc, best;
      s = eff_subj();
      v = eff_var();
      total = 1 << (s * v);
      st = states_seen & (total - 1);
      for (int p = 0; p < (1 << s); p++) begin
         id = 0;
         for (int k = 0; k < v; k++)
            if ((p & (st >> (k * s))) != p) id |= 1 << k;
         slot = ((p << PRED_VAR) | id) & (STORE_SIZE - 1);
         if (part_mass[slot] > 32'hFFFF_FFFF - mass) part_mass[slot] = MASS_SAT;
         else part_mass[slot] = part_mass[slot] + mass;
      end
      if (states_seen + 1 < total) begin
         states_seen++;
         return 0;
      end
      best = SCORE_START;
      r.pool = '0;
      for (int p = 0; p < (1 << s); p++) begin
         sc = 0;
         for (int k = 0; k < (1 << v); k++) begin
            m = part_mass[((p << PRED_VAR) | k) & (STORE_SIZE - 1)];
            d = (m > cfg_target) ? m - cfg_target : cfg_target - m;
            sc += d;
            if (sc > SCORE_SAT) sc = SCORE_SAT;
         end
         if (sc < best) begin
            best = sc;
            r.pool = p[POOL_OUT_W-1:0];
         end
      end
      r.score = best[SCORE_W-1:0];
      for (int i = 0; i < STORE_SIZE; i++) part_mass[i] = '0;
      states_seen = 0;
      return 1;
   endfunction

   task automatic report(input string what, input longint unsigned got, input longint unsigned want);
      err_count++;
      if (err_count <= 30)
         $display("MISMATCH %s: got %0h, want %0h", what, got, want);
   endtask

   // send one state word; leaves valid high, called at a rising edge
   task automatic send_mass(input logic [MASS_W-1:0] mass);
      int gap;
      pick_type r;
      gap = $urandom_range(0, tx_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_state_mass <= mass;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
      if (accumulate_mass(mass, r)) begin
         pick_q.push_back(r);
         runs_done++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pick_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MASS_W-1:0] data);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NUM_SUBJECTS: cfg_subj   = data[SUBJ_W-1:0];
         CSR_NUM_VARIANTS: cfg_var    = data[VAR_W-1:0];
         CSR_TARGET_MASS:  cfg_target = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [MASS_W-1:0] pick_mass(input int mode, input int unsigned n);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, (32'h8000_0000 / n) * 2);
         2: return $urandom_range(32'hC000_0000, 32'hFFFF_FFFF);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h0;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return 32'h1;
            endcase
         end
      endcase
   endfunction

   task automatic stream_run(input int mode);
      int unsigned n;
      n = run_len();
      for (int unsigned i = 0; i < n; i++) send_mass(pick_mass(mode, n));
   endtask

   task automatic set_shape(input int s, input int v, input logic [MASS_W-1:0] tgt);
      write_reg(CSR_NUM_SUBJECTS, {28'($urandom), 4'(s)});
      write_reg(CSR_NUM_VARIANTS, {30'($urandom), 2'(v)});
      write_reg(CSR_TARGET_MASS, tgt);
   endtask

   task automatic test_directed();
      tx_max = 0;
      rx_max = 0;
      set_shape(1, 1, 32'h4000_0000);
      send_mass(32'h0);
      send_mass(32'hFFFF_FFFF);
      send_mass(32'hFFFF_FFFF);      // saturate the accumulators
      send_mass(32'hFFFF_FFFF);
      send_mass(32'h8000_0000);
      send_mass(32'h0);
      write_reg(CSR_TARGET_MASS, 32'h0);
      send_mass(32'h0);
      send_mass(32'h0);
      write_reg(CSR_TARGET_MASS, 32'hFFFF_FFFF);
      send_mass(32'h8000_0000);
      send_mass(32'h8000_0000);
      // out-of-range counts clamp
      set_shape(0, 0, 32'h8000_0000);
      send_mass(32'h1);
      send_mass(32'h7FFF_FFFF);
      set_shape(2, 3, 32'h2000_0000);
      stream_run(1);
      write_reg(CSR_NUM_SUBJECTS, 32'hF);
      write_reg(CSR_NUM_VARIANTS, 32'h1);
      write_reg(CSR_UNUSED, $urandom);     // no register behind this index
      stream_run(3);
      // shrink the run in the middle: count carries over
      set_shape(2, 1, 32'h4000_0000);
      send_mass(32'h3000_0000);
      send_mass(32'h1000_0000);
      write_reg(CSR_NUM_SUBJECTS, 32'h1);
      send_mass(32'h5000_0000);
   endtask

   task automatic test_random();
      int r, s, v, vi;
      logic [MASS_W-1:0] tgt;
      while (items_sent < 1100) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin s = 8; v = 1; end
         else if (r == 1) begin s = 4; v = 2; end
         else if (r == 2) begin s = $urandom_range(9, 15); v = 1; end
         else if (r == 3) begin s = $urandom_range(0, 3); v = 3; end
         else begin
            s = $urandom_range(1, 6);
            v = (s <= 3) ? $urandom_range(0, 2) : 1;
         end
         vi = (v == 0) ? 1 : (v > 2 ? 2 : v);
         case ($urandom_range(0, 4))
            0: tgt = $urandom;
            1: tgt = 32'h0;
            2: tgt = 32'h8000_0000;
            default: tgt = 32'h8000_0000 >> vi;
         endcase
         set_shape(s, v, tgt);
         repeat ($urandom_range(1, 3)) begin
            tx_max = $urandom_range(0, 1) ? 18 : 0;
            rx_max = $urandom_range(0, 1) ? 18 : 0;
            stream_run($urandom_range(0, 3));
         end
      end
   endtask

   // receiver stalls long while runs keep coming, so the input backs up
   task automatic test_backpressure();
      set_shape(2, 1, 32'h4000_0000);
      tx_max = 0;
      hold_left = 3000;
      repeat (6) stream_run(1);
      wait_drained();
   endtask

   // sender waits for every result before each run
   task automatic test_drained_runs();
      set_shape(3, 2, 32'h2000_0000);
      tx_max = 18;
      rx_max = 18;
      repeat (4) begin
         stream_run(1);
         wait_drained();
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_fire) begin
         rx_wait = $urandom_range(0, rx_max);
         if (rx_wait == 0) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            rx_wait--;
         end
      end else if (!rsp_ready) begin
         if (rx_wait == 0) rsp_ready <= 1'b1;
         else rx_wait--;
      end
   end

   // signals are stable at the falling edge; a handshake seen here fires next edge
   always @(negedge clock) begin
      pick_type want;
      rsp_fire = rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_fire) begin
            picks_seen++;
            if (pick_q.size() == 0) report("result with nothing pending", rsp_best_pool, 0);
            else begin
               want = pick_q.pop_front();
               if (rsp_best_pool !== want.pool) report("best_pool", rsp_best_pool, want.pool);
               if (rsp_best_score !== want.score)
                  report("best_score", rsp_best_score, want.score);
            end
         end
         if ((req_valid && req_ready) || rsp_fire || (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb_halving_pool_selector: done, errors");
            $finish;
         end
      end
   end

   initial begin
      cfg_subj   = SUBJ_RESET;
      cfg_var    = VAR_RESET;
      cfg_target = TARGET_RESET;
      clear_pred();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_drained_runs();
      test_random();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d state words in %0d runs, %0d results checked",
               items_sent, runs_done, picks_seen);
      $display("shapes 1..8 subjects, 1..2 variants, clamped counts, mid-run resize, stalls");
      if (err_count == 0 && pick_q.size() == 0)
         $display("tb_halving_pool_selector: done, clean");
      else
         $display("tb_halving_pool_selector: done, errors");
      $finish;
   end

endmodule
